// ===== sv/page_free_stack_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Page free-stack allocator assertion macros
// Shared property wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_STACK_ALLOCATOR_ASSERT_SVH
`define PAGE_FREE_STACK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition holds at every edge outside reset
`define PFSA_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pfsa: invariant violated");
// consequent holds in the same cycle as the antecedent
`define PFSA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfsa: implication violated");
// consequent holds in the cycle after the antecedent
`define PFSA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfsa: next-cycle check violated");
`else
`define PFSA_ASSERT_ALWAYS(name, clk, rst, cond)
`define PFSA_ASSERT_IMP(name, clk, rst, ante, cons)
`define PFSA_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/pfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsa_pkg
// Constants, codes and types shared by the page free-stack allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

   localparam int ADDR_W     = 40;
   localparam int PAGE_SHIFT = 12;
   localparam int MAX_PAGES  = 1024;

   localparam int IDX_W  = $clog2(MAX_PAGES);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int BASE_W = ADDR_W + 1;
   localparam int DIFF_W = ADDR_W + 2;
   localparam int OFF_W  = BASE_W - PAGE_SHIFT;

   localparam int CMD_W      = 2;
   localparam int STS_W      = 3;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [BASE_W-1:0] PAGE_MASK = BASE_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [OFF_W-1:0]  MAX_OFF   = OFF_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_PAGES);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

   // register index, taken from the top address bit
   localparam logic REG_START = 1'b0;
   localparam logic REG_STOP  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK         = 3'd0,
      STS_OOM        = 3'd1,
      STS_MISALIGNED = 3'd2,
      STS_RANGE      = 3'd3,
      STS_DOUBLE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT_SIZE,
      S_INIT_FILL,
      S_ALLOC_RD,
      S_FREE_CHK,
      S_FREE_RD,
      S_DONE
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted;
      logic [CNT_W-1:0]  free_count;
      logic [CNT_W-1:0]  total_count;
   } rsp_type;

endpackage

// ===== sv/pfsa_ram.sv =====
// ----------------------------------------------------------------------------
// pfsa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfsa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Command sequencer: address checks, stack pointer and memory read-modify-write.
// ----------------------------------------------------------------------------
`include "page_free_stack_allocator_assert.svh"

module pfsa_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pfsa_pkg::CMD_W-1:0]        req_cmd,
   input  logic [pfsa_pkg::ADDR_W-1:0]       req_addr,
   input  logic [pfsa_pkg::ADDR_W-1:0]       region_start,
   input  logic [pfsa_pkg::ADDR_W-1:0]       region_stop,
   input  logic [pfsa_pkg::BASE_W-1:0]       region_base,
   output logic                              stack_we,
   output logic [pfsa_pkg::IDX_W-1:0]        stack_waddr,
   output logic [pfsa_pkg::IDX_W-1:0]        stack_wdata,
   output logic                              stack_re,
   output logic [pfsa_pkg::IDX_W-1:0]        stack_raddr,
   input  logic [pfsa_pkg::IDX_W-1:0]        stack_rdata,
   output logic                              marks_we,
   output logic [pfsa_pkg::IDX_W-1:0]        marks_waddr,
   output logic [0:0]                        marks_wdata,
   output logic                              marks_re,
   output logic [pfsa_pkg::IDX_W-1:0]        marks_raddr,
   input  logic [0:0]                        marks_rdata,
   input  logic                              out_ready,
   output logic                              res_valid,
   output pfsa_pkg::rsp_type                 res
);

   pfsa_pkg::state_type               state_ff, state_in;
   logic [pfsa_pkg::CNT_W-1:0]        depth_ff, depth_in;
   logic [pfsa_pkg::CNT_W-1:0]        managed_ff, managed_in;
   logic [pfsa_pkg::CNT_W-1:0]        fill_ff, fill_in;
   logic [pfsa_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [pfsa_pkg::OFF_W-1:0]        off_ff, off_in;
   logic                              neg_ff, neg_in;
   logic                              out_ff, out_in;
   logic                              mis_ff, mis_in;
   pfsa_pkg::status_type              status_ff, status_in;
   logic [pfsa_pkg::ADDR_W-1:0]       granted_ff, granted_in;

   logic [pfsa_pkg::DIFF_W-1:0]       sub_a;
   logic [pfsa_pkg::DIFF_W-1:0]       diff;
   logic [pfsa_pkg::CNT_W-1:0]        depth_dec;
   logic [pfsa_pkg::CNT_W-1:0]        fill_inc;
   logic [pfsa_pkg::CNT_W-1:0]        init_n;
   logic [pfsa_pkg::BASE_W-1:0]       grant_sum;
   logic                              unmanaged;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pfsa_pkg::S_IDLE;
         depth_ff   <= '0;
         managed_ff <= '0;
      end else begin
         state_ff   <= state_in;
         depth_ff   <= depth_in;
         managed_ff <= managed_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      idx_ff     <= idx_in;
      off_ff     <= off_in;
      neg_ff     <= neg_in;
      out_ff     <= out_in;
      mis_ff     <= mis_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   // free uses addr - base; init uses stop - base
   assign sub_a = (pfsa_pkg::cmd_type'(req_cmd) == pfsa_pkg::CMD_FREE)
                ? {2'b00, req_addr} : {2'b00, region_stop};
   assign diff  = sub_a - {1'b0, region_base};

   assign depth_dec = depth_ff - pfsa_pkg::CNT_ONE;
   assign fill_inc  = fill_ff + pfsa_pkg::CNT_ONE;
   assign unmanaged = off_ff >= {{(pfsa_pkg::OFF_W - pfsa_pkg::CNT_W){1'b0}}, managed_ff};
   assign grant_sum = region_base
                    + ({{(pfsa_pkg::BASE_W - pfsa_pkg::IDX_W){1'b0}}, stack_rdata}
                       << pfsa_pkg::PAGE_SHIFT);

   always_comb begin
      if (neg_ff) begin
         init_n = '0;
      end else if (off_ff >= pfsa_pkg::MAX_OFF) begin
         init_n = pfsa_pkg::MAX_CNT;
      end else begin
         init_n = off_ff[pfsa_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      state_in    = state_ff;
      depth_in    = depth_ff;
      managed_in  = managed_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      off_in      = off_ff;
      neg_in      = neg_ff;
      out_in      = out_ff;
      mis_in      = mis_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      stack_we    = 1'b0;
      stack_waddr = fill_ff[pfsa_pkg::IDX_W-1:0];
      stack_wdata = fill_ff[pfsa_pkg::IDX_W-1:0];
      stack_re    = 1'b0;
      stack_raddr = depth_dec[pfsa_pkg::IDX_W-1:0];
      marks_we    = 1'b0;
      marks_waddr = fill_ff[pfsa_pkg::IDX_W-1:0];
      marks_wdata = 1'b1;
      marks_re    = 1'b0;
      marks_raddr = off_ff[pfsa_pkg::IDX_W-1:0];
      res_valid   = (state_ff == pfsa_pkg::S_DONE);
      req_ready   = (state_ff == pfsa_pkg::S_IDLE)
                 || ((state_ff == pfsa_pkg::S_DONE) && out_ready);

      unique case (state_ff)
         pfsa_pkg::S_IDLE: begin
         end
         pfsa_pkg::S_INIT_SIZE: begin
            depth_in   = init_n;
            managed_in = init_n;
            fill_in    = '0;
            state_in   = (init_n == '0) ? pfsa_pkg::S_DONE : pfsa_pkg::S_INIT_FILL;
         end
         pfsa_pkg::S_INIT_FILL: begin
            // push page indices in ascending order and mark each free
            stack_we = 1'b1;
            marks_we = 1'b1;
            fill_in  = fill_inc;
            if (fill_inc == managed_ff) begin
               state_in = pfsa_pkg::S_DONE;
            end
         end
         pfsa_pkg::S_ALLOC_RD: begin
            marks_we    = 1'b1;
            marks_waddr = stack_rdata;
            marks_wdata = 1'b0;
            depth_in    = depth_dec;
            granted_in  = grant_sum[pfsa_pkg::ADDR_W-1:0];
            status_in   = pfsa_pkg::STS_OK;
            state_in    = pfsa_pkg::S_DONE;
         end
         pfsa_pkg::S_FREE_CHK: begin
            priority if (mis_ff) begin
               status_in = pfsa_pkg::STS_MISALIGNED;
               state_in  = pfsa_pkg::S_DONE;
            end else if (out_ff || neg_ff || unmanaged) begin
               status_in = pfsa_pkg::STS_RANGE;
               state_in  = pfsa_pkg::S_DONE;
            end else begin
               marks_re = 1'b1;
               idx_in   = off_ff[pfsa_pkg::IDX_W-1:0];
               state_in = pfsa_pkg::S_FREE_RD;
            end
         end
         pfsa_pkg::S_FREE_RD: begin
            priority if (marks_rdata[0]) begin
               status_in = pfsa_pkg::STS_DOUBLE;
            end else if (depth_ff >= pfsa_pkg::MAX_CNT) begin
               status_in = pfsa_pkg::STS_RANGE;
            end else begin
               marks_we    = 1'b1;
               marks_waddr = idx_ff;
               stack_we    = 1'b1;
               stack_waddr = depth_ff[pfsa_pkg::IDX_W-1:0];
               stack_wdata = idx_ff;
               depth_in    = depth_ff + pfsa_pkg::CNT_ONE;
               status_in   = pfsa_pkg::STS_OK;
            end
            state_in = pfsa_pkg::S_DONE;
         end
         pfsa_pkg::S_DONE: begin
            if (out_ready) begin
               state_in = pfsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pfsa_pkg::S_IDLE;
         end
      endcase

      // start a new transaction; the held result leaves on the same edge
      if (req_valid && req_ready) begin
         off_in     = diff[pfsa_pkg::ADDR_W:pfsa_pkg::PAGE_SHIFT];
         neg_in     = diff[pfsa_pkg::DIFF_W-1];
         out_in     = (req_addr < region_start) || (req_addr >= region_stop);
         mis_in     = (req_addr[pfsa_pkg::PAGE_SHIFT-1:0] != '0);
         status_in  = pfsa_pkg::STS_OK;
         granted_in = '0;
         unique case (pfsa_pkg::cmd_type'(req_cmd))
            pfsa_pkg::CMD_INIT: begin
               state_in = pfsa_pkg::S_INIT_SIZE;
            end
            pfsa_pkg::CMD_ALLOC: begin
               if (depth_ff == '0) begin
                  status_in = pfsa_pkg::STS_OOM;
                  state_in  = pfsa_pkg::S_DONE;
               end else begin
                  stack_re = 1'b1;
                  state_in = pfsa_pkg::S_ALLOC_RD;
               end
            end
            pfsa_pkg::CMD_FREE: begin
               state_in = pfsa_pkg::S_FREE_CHK;
            end
            default: begin
               state_in = pfsa_pkg::S_DONE;
            end
         endcase
      end
   end

   assign res.status      = status_ff;
   assign res.granted     = granted_ff;
   assign res.free_count  = depth_ff;
   assign res.total_count = managed_ff;

   `PFSA_ASSERT_ALWAYS(a_depth_within_managed, clock, reset, depth_ff <= managed_ff)
   `PFSA_ASSERT_ALWAYS(a_managed_within_max, clock, reset, managed_ff <= pfsa_pkg::MAX_CNT)
   `PFSA_ASSERT_NEXT(a_alloc_pops_one, clock, reset, state_ff == pfsa_pkg::S_ALLOC_RD, depth_ff == $past(depth_ff) - pfsa_pkg::CNT_ONE)
   `PFSA_ASSERT_IMP(a_push_only_clear, clock, reset, (state_ff == pfsa_pkg::S_FREE_RD) && stack_we, !marks_rdata[0] && (idx_ff < managed_ff))

endmodule

// ===== sv/pfsa_out.sv =====
// ----------------------------------------------------------------------------
// pfsa_out
// Result register between the sequencer and the result stream.
// ----------------------------------------------------------------------------
module pfsa_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_valid,
   input  pfsa_pkg::rsp_type                 load_data,
   output logic                              load_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [pfsa_pkg::STS_W-1:0]        rsp_tuser
);

   logic              valid_ff, valid_in;
   pfsa_pkg::rsp_type data_ff;

   assign load_ready = !valid_ff || rsp_tready;
   assign valid_in   = (load_valid && load_ready) || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.status;
   assign rsp_tdata  = {{(pfsa_pkg::RSP_DATA_W - pfsa_pkg::ADDR_W - 2 * pfsa_pkg::CNT_W){1'b0}},
                        data_ff.total_count, data_ff.free_count, data_ff.granted};

endmodule

// ===== sv/page_free_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// page_free_stack_allocator
// Hands out fixed-size pages of a physical region from a LIFO free stack.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  req      | in  | tvalid / tready      | tuser: command, tdata: page_address
//  rsp      | out | tvalid / tready      | tuser: status, tdata: granted, counts
//  csr      | in  | psel/penable/pready  | region_start @0x0, region_stop @0x8
//
//  Alloc reads the stack, then writes the mark; free runs the range check,
//  the mark read, then the push, and ends after the check when the alignment
//  or range check refuses it; out-of-memory and unused commands go straight
//  to the done state. Init sizes the region, then the fill walks one stack
//  and one mark entry per cycle through the single write port of each memory.
//  Reset clears the counters only; no clearing pass runs over the memories.
//  A stalled result stream holds the sequencer in its done state; the result
//  register still accepts one finished transaction ahead of it.
//
module page_free_stack_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfsa_pkg::REQ_DATA_W-1:0]   req_tdata,   // [39:0] page_address
   input  logic [pfsa_pkg::CMD_W-1:0]        req_tuser,   // [1:0] command
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [39:0] granted_address, [50:40] free_count, [61:51] total_count, [63:62] zero
   output logic [pfsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [pfsa_pkg::STS_W-1:0]        rsp_tuser,   // [2:0] status
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pfsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pfsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [pfsa_pkg::ADDR_W-1:0] region_start_ff;
   logic [pfsa_pkg::ADDR_W-1:0] region_stop_ff;
   logic [pfsa_pkg::BASE_W-1:0] region_base_ff, region_base_in;
   logic                        csr_wr;

   logic                        stack_we, stack_re;
   logic [pfsa_pkg::IDX_W-1:0]  stack_waddr, stack_wdata, stack_raddr, stack_rdata;
   logic                        marks_we, marks_re;
   logic [pfsa_pkg::IDX_W-1:0]  marks_waddr, marks_raddr;
   logic [0:0]                  marks_wdata, marks_rdata;

   logic                        out_ready;
   logic                        res_valid;
   pfsa_pkg::rsp_type           res;

   // Register writes complete in the access phase; decode on the top address bit.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_stop_ff  <= '0;
         region_base_ff  <= '0;
      end else begin
         if (csr_wr && (csr_paddr[pfsa_pkg::CSR_ADDR_W-1] == pfsa_pkg::REG_START)) begin
            region_start_ff <= csr_pwdata[pfsa_pkg::ADDR_W-1:0];
            region_base_ff  <= region_base_in;
         end
         if (csr_wr && (csr_paddr[pfsa_pkg::CSR_ADDR_W-1] == pfsa_pkg::REG_STOP)) begin
            region_stop_ff <= csr_pwdata[pfsa_pkg::ADDR_W-1:0];
         end
      end
   end

   // Round the written start up to a page boundary so the base lands together
   // with the register; one bit wider so the carry is kept.
   assign region_base_in = ({1'b0, csr_pwdata[pfsa_pkg::ADDR_W-1:0]} + pfsa_pkg::PAGE_MASK)
                         & ~pfsa_pkg::PAGE_MASK;

   always_comb begin
      if (csr_paddr[pfsa_pkg::CSR_ADDR_W-1] == pfsa_pkg::REG_STOP) begin
         csr_prdata = {{(pfsa_pkg::CSR_DATA_W - pfsa_pkg::ADDR_W){1'b0}}, region_stop_ff};
      end else begin
         csr_prdata = {{(pfsa_pkg::CSR_DATA_W - pfsa_pkg::ADDR_W){1'b0}}, region_start_ff};
      end
   end

   // Sequencer: owns the stack pointer and drives both memories.
   pfsa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (req_tuser),
      .req_addr     (req_tdata[pfsa_pkg::ADDR_W-1:0]),
      .region_start (region_start_ff),
      .region_stop  (region_stop_ff),
      .region_base  (region_base_ff),
      .stack_we     (stack_we),
      .stack_waddr  (stack_waddr),
      .stack_wdata  (stack_wdata),
      .stack_re     (stack_re),
      .stack_raddr  (stack_raddr),
      .stack_rdata  (stack_rdata),
      .marks_we     (marks_we),
      .marks_waddr  (marks_waddr),
      .marks_wdata  (marks_wdata),
      .marks_re     (marks_re),
      .marks_raddr  (marks_raddr),
      .marks_rdata  (marks_rdata),
      .out_ready    (out_ready),
      .res_valid    (res_valid),
      .res          (res)
   );

   // Free stack of page indices; entries above the stack pointer are never read.
   pfsa_ram #(
      .WIDTH (pfsa_pkg::IDX_W),
      .DEPTH (pfsa_pkg::MAX_PAGES)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_en   (stack_re),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   // One free bit per page; only pages below the managed count are consulted,
   // and init writes all of those.
   pfsa_ram #(
      .WIDTH (1),
      .DEPTH (pfsa_pkg::MAX_PAGES)
   ) u_marks_ram (
      .clock   (clock),
      .wr_en   (marks_we),
      .wr_addr (marks_waddr),
      .wr_data (marks_wdata),
      .rd_en   (marks_re),
      .rd_addr (marks_raddr),
      .rd_data (marks_rdata)
   );

   // Result register: frees the sequencer while the consumer stalls.
   pfsa_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .load_ready (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
